/* hw/rtl/ulrr_pkg.sv */
// Shared types and constants for the line ring receiver.
// Beat structs, pop control structs, character codes, default sizes.
`timescale 1ns / 1ps

package ulrr_pkg;

    localparam int SLOTS_DEF    = 4;
    localparam int LINE_CAP_DEF = 60;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last;
        logic       empty_res;
        logic       overrun;
        logic [5:0] line_length;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic empty;
        logic ovr;
    } t_pop_req;

    typedef struct packed {
        logic idle;
        logic streaming;
    } t_pop_stat;

endpackage

/* hw/rtl/uart_line_ring_receiver_core.sv */
// Top level of the line ring receiver: byte gathering, ring pointers and counts.
// Uses ulrr_pkg, ulrr_ram (line bytes and line lengths) and ulrr_pop_seq.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_in_beat    | sink
//   out     | o_out_valid, i_out_ready, o_out_beat | source
//
// A pop runs a length RAM read, length capture, one line RAM read per byte,
// then the output load; when no line waits it loads an empty result instead.
// The line RAM read port sets the one-byte-per-cycle stream while the output
// is not stalled.
// o_in_ready is low while a pop runs. Output stalls hold the stream in place.
// Reset is synchronous; RAM contents are not cleared.
`timescale 1ns / 1ps

module uart_line_ring_receiver_core #(
    parameter int SLOTS    = ulrr_pkg::SLOTS_DEF,
    parameter int LINE_CAP = ulrr_pkg::LINE_CAP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ulrr_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ulrr_pkg::t_out_beat o_out_beat
);
    import ulrr_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int FW    = $clog2(LINE_CAP);
    localparam int DEPTH = SLOTS * LINE_CAP;
    localparam int AW    = $clog2(DEPTH);

    logic [SW-1:0] r_ws, n_ws;
    logic [SW-1:0] r_rs, n_rs;
    logic [AW-1:0] r_wr_base, n_wr_base;
    logic [AW-1:0] r_rd_base, n_rd_base;
    logic [FW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_lw, n_lw;
    logic          r_ovr, n_ovr;
    logic          r_skip, n_skip;

    logic          acc;
    logic          is_byte;
    logic          is_pop;
    logic          full;
    logic          is_cr;
    logic          is_lf;
    logic          byte_we;
    logic          len_we;
    t_pop_req      req;
    t_pop_stat     stat;

    logic          byte_re;
    logic [AW-1:0] byte_raddr;
    logic [7:0]    byte_q;
    logic [FW-1:0] len_q;

    assign acc     = i_in_valid && o_in_ready;
    assign is_byte = acc && (i_in_beat.kind == KIND_BYTE);
    assign is_pop  = acc && (i_in_beat.kind == KIND_POP);
    assign full    = (r_lw == LW'(SLOTS));
    assign is_cr   = (i_in_beat.rx_byte == CH_CR);
    assign is_lf   = (i_in_beat.rx_byte == CH_LF);

    always_comb begin
        n_ws      = r_ws;
        n_rs      = r_rs;
        n_wr_base = r_wr_base;
        n_rd_base = r_rd_base;
        n_fill    = r_fill;
        n_lw      = r_lw;
        n_ovr     = r_ovr;
        n_skip    = r_skip;
        byte_we   = 1'b0;
        len_we    = 1'b0;
        req       = '0;
        if (is_byte && !is_cr) begin
            if (!is_lf) begin
                n_skip = r_skip | full;
                if (r_fill < FW'(LINE_CAP - 1)) begin
                    byte_we = !n_skip;
                    n_fill  = r_fill + 1'b1;
                end
            end else if (r_fill != '0) begin
                if (r_skip || full) begin
                    n_ovr = 1'b1;
                end else begin
                    len_we = 1'b1;
                    if (r_ws == SW'(SLOTS - 1)) begin
                        n_ws      = '0;
                        n_wr_base = '0;
                    end else begin
                        n_ws      = r_ws + 1'b1;
                        n_wr_base = r_wr_base + AW'(LINE_CAP);
                    end
                    n_lw = r_lw + 1'b1;
                end
                n_fill = '0;
                n_skip = 1'b0;
            end
        end
        if (is_pop) begin
            req.start = 1'b1;
            req.ovr   = r_ovr;
            req.empty = (r_lw == '0);
            n_ovr     = 1'b0;
            if (r_lw != '0) begin
                if (r_rs == SW'(SLOTS - 1)) begin
                    n_rs      = '0;
                    n_rd_base = '0;
                end else begin
                    n_rs      = r_rs + 1'b1;
                    n_rd_base = r_rd_base + AW'(LINE_CAP);
                end
                n_lw = r_lw - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_rs      <= '0;
            r_wr_base <= '0;
            r_rd_base <= '0;
            r_fill    <= '0;
            r_lw      <= '0;
            r_ovr     <= 1'b0;
            r_skip    <= 1'b0;
        end else begin
            r_ws      <= n_ws;
            r_rs      <= n_rs;
            r_wr_base <= n_wr_base;
            r_rd_base <= n_rd_base;
            r_fill    <= n_fill;
            r_lw      <= n_lw;
            r_ovr     <= n_ovr;
            r_skip    <= n_skip;
        end
    end

    ulrr_ram #(
        .W     (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (r_wr_base + AW'(r_fill)),
        .i_wdata (i_in_beat.rx_byte),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_q)
    );

    ulrr_ram #(
        .W     (FW),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_ws),
        .i_wdata (r_fill),
        .i_re    (is_pop),
        .i_raddr (r_rs),
        .o_rdata (len_q)
    );

    ulrr_pop_seq #(
        .SLOTS    (SLOTS),
        .LINE_CAP (LINE_CAP)
    ) u_pop_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rd_base    (r_rd_base),
        .i_len_q      (len_q),
        .o_byte_re    (byte_re),
        .o_byte_raddr (byte_raddr),
        .i_byte_q     (byte_q),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_beat   (o_out_beat)
    );

    assign o_in_ready = stat.idle;

endmodule

/* hw/rtl/ulrr_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read data holds while no read is issued. No package dependency.
`timescale 1ns / 1ps

module ulrr_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 240,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ulrr_pop_seq.sv */
// Pop sequencer: fetches the line length, streams line bytes from the line RAM
// through a pending stage into the output register. Depends on ulrr_pkg.
`timescale 1ns / 1ps

module ulrr_pop_seq #(
    parameter int SLOTS    = ulrr_pkg::SLOTS_DEF,
    parameter int LINE_CAP = ulrr_pkg::LINE_CAP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ulrr_pkg::t_pop_req                   i_req,
    input  logic [$clog2(SLOTS*LINE_CAP)-1:0]    i_rd_base,
    input  logic [$clog2(LINE_CAP)-1:0]          i_len_q,
    output logic                                 o_byte_re,
    output logic [$clog2(SLOTS*LINE_CAP)-1:0]    o_byte_raddr,
    input  logic [7:0]                           i_byte_q,
    output ulrr_pkg::t_pop_stat                  o_stat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ulrr_pkg::t_out_beat                  o_out_beat
);
    import ulrr_pkg::*;

    localparam int FW = $clog2(LINE_CAP);
    localparam int AW = $clog2(SLOTS * LINE_CAP);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EMPTY  = 2'd1;
    localparam logic [1:0] S_LEN    = 2'd2;
    localparam logic [1:0] S_STREAM = 2'd3;

    logic [1:0]    r_state;
    logic [AW-1:0] r_base;
    logic [FW-1:0] r_len;
    logic [FW-1:0] r_idx;
    logic          r_ovr;
    logic          r_pend;
    logic          r_pend_last;
    logic          r_oval;
    t_out_beat     r_out;
    t_out_beat     n_out;

    logic out_free;
    logic mv;
    logic iss;
    logic load;

    assign out_free = !r_oval || i_out_ready;
    assign mv       = (r_state == S_STREAM) && r_pend && out_free;
    assign iss      = (r_state == S_STREAM) && (r_idx != r_len) && (!r_pend || mv);
    assign load     = mv || ((r_state == S_EMPTY) && out_free);

    assign o_byte_re    = iss;
    assign o_byte_raddr = r_base + AW'(r_idx);

    always_comb begin
        if (r_state == S_EMPTY) begin
            n_out.line_byte   = 8'd0;
            n_out.last        = 1'b1;
            n_out.empty_res   = 1'b1;
            n_out.overrun     = r_ovr;
            n_out.line_length = 6'd0;
        end else begin
            n_out.line_byte   = i_byte_q;
            n_out.last        = r_pend_last;
            n_out.empty_res   = 1'b0;
            n_out.overrun     = r_ovr;
            n_out.line_length = 6'(r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ovr   <= i_req.ovr;
                        r_base  <= i_rd_base;
                        r_state <= i_req.empty ? S_EMPTY : S_LEN;
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_LEN: begin
                    r_len   <= i_len_q;
                    r_idx   <= '0;
                    r_state <= S_STREAM;
                end
                S_STREAM: begin
                    if (mv && r_pend_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (iss) begin
                r_idx       <= r_idx + 1'b1;
                r_pend_last <= ((r_idx + 1'b1) == r_len);
            end
            r_pend <= iss || (r_pend && !mv);
            if (load) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.streaming = (r_state == S_STREAM);
    assign o_out_valid      = r_oval;
    assign o_out_beat       = r_out;

endmodule
